FILE: src/fadr_pkg.sv
// Package for the fraction add/reduce core: widths and sequencer state codes.
package fadr_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int FIELD_WIDTH   = 32;
  localparam int WORD_WIDTH    = 64;
  localparam int STATE_WIDTH   = 4;

  localparam logic [STATE_WIDTH-1:0] S_IDLE     = 4'd0;
  localparam logic [STATE_WIDTH-1:0] S_LOAD     = 4'd1;
  localparam logic [STATE_WIDTH-1:0] S_GCD_INIT = 4'd2;
  localparam logic [STATE_WIDTH-1:0] S_GCD      = 4'd3;
  localparam logic [STATE_WIDTH-1:0] S_DIV_INIT = 4'd4;
  localparam logic [STATE_WIDTH-1:0] S_DIV      = 4'd5;
  localparam logic [STATE_WIDTH-1:0] S_STORE    = 4'd6;
  localparam logic [STATE_WIDTH-1:0] S_MUL      = 4'd7;
  localparam logic [STATE_WIDTH-1:0] S_ADD      = 4'd8;
  localparam logic [STATE_WIDTH-1:0] S_ADD2     = 4'd9;
  localparam logic [STATE_WIDTH-1:0] S_OUT      = 4'd10;

  localparam logic [1:0] PH_LEFT  = 2'd0;
  localparam logic [1:0] PH_RIGHT = 2'd1;
  localparam logic [1:0] PH_SUM   = 2'd2;

endpackage

FILE: src/fraction_add_reduce_core.sv
// Fraction add/reduce core: sums two signed fractions and returns the result in lowest terms.
//
// One item is in flight at a time; in_tready is high only while the core is idle. Each operand
// is reduced by its gcd, the cross products are formed on one shared multiplier, and the sum is
// reduced again. All gcd and division steps run on one shared 65-bit add/subtract unit: each
// binary gcd loop steps by shift, swap or subtract, and each exact division has a setup and a
// store step. With both denominators nonzero an item runs six divisions and three gcd loops;
// with both denominators zero only the sum is divided, after one gcd loop.
// A result held by out_tready adds its wait to the item. These loops set the item time.
// A zero denominator turns its operand into 1/1 and sets operand_fixed; a zero sum is 0/1.
module fraction_add_reduce_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // left_num, left_den, right_num, right_den
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // sum_num[63:0], sum_den[62:0], zero pad
  output logic         out_tuser   // operand_fixed
);

  localparam int W  = fadr_pkg::OPERAND_WIDTH;
  localparam int FW = fadr_pkg::FIELD_WIDTH;
  localparam int DW = fadr_pkg::WORD_WIDTH;

  logic [fadr_pkg::STATE_WIDTH-1:0] state_r, state_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic          div_sel_r, div_sel_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [6:0]    k_r, k_nxt;
  logic [DW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [DW-1:0] xn_r, xn_nxt, xd_r, xd_nxt;
  logic [DW-1:0] g_r, g_nxt, q_r, q_nxt, rem_r, rem_nxt;
  logic [DW-1:0] t1_r, t1_nxt, t2_r, t2_nxt, den_r, den_nxt;
  logic          neg_r, neg_nxt, fixed_r, fixed_nxt;
  logic [W-1:0]  opm_r [4], opm_nxt [4];
  logic          ops_r [4], ops_nxt [4];
  logic [W-1:0]  ln_r, ln_nxt, ld_r, ld_nxt, rn_r, rn_nxt, rd_r, rd_nxt;
  logic          lneg_r, lneg_nxt, rneg_r, rneg_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [DW-1:0] onum_r, onum_nxt;
  logic [DW-2:0] oden_r, oden_nxt;
  logic          ofix_r, ofix_nxt;

  logic [DW:0]   alu_x, alu_y;
  logic          alu_sub;
  logic [DW+1:0] alu_res;
  logic          borrow;
  logic [W-1:0]  mul_a, mul_b;
  logic [DW-1:0] mul_p;
  logic [DW:0]   r2;
  logic [W-1:0]  fld [4];
  logic [W-1:0]  store_mag_n, store_mag_d;
  logic          store_neg;

  assign alu_res = alu_sub ? ({1'b0, alu_x} - {1'b0, alu_y}) : ({1'b0, alu_x} + {1'b0, alu_y});
  assign borrow  = alu_res[DW+1];
  assign mul_p   = DW'(mul_a) * DW'(mul_b);
  assign r2      = {rem_r, q_r[DW-1]};

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      fld[i] = in_tdata[i*FW +: W];
    end
  end

  assign store_mag_n = q_r[W-1:0];
  assign store_mag_d = q_r[W-1:0];

  always_comb begin
    state_nxt = state_r; phase_nxt = phase_r; div_sel_nxt = div_sel_r; cnt_nxt = cnt_r;
    k_nxt = k_r; a_nxt = a_r; b_nxt = b_r; xn_nxt = xn_r; xd_nxt = xd_r;
    g_nxt = g_r; q_nxt = q_r; rem_nxt = rem_r;
    t1_nxt = t1_r; t2_nxt = t2_r; den_nxt = den_r;
    neg_nxt = neg_r; fixed_nxt = fixed_r;
    ln_nxt = ln_r; ld_nxt = ld_r; rn_nxt = rn_r; rd_nxt = rd_r;
    lneg_nxt = lneg_r; rneg_nxt = rneg_r;
    ovalid_nxt = ovalid_r; onum_nxt = onum_r; oden_nxt = oden_r; ofix_nxt = ofix_r;
    for (int i = 0; i < 4; i++) begin
      opm_nxt[i] = opm_r[i];
      ops_nxt[i] = ops_r[i];
    end
    alu_x = '0; alu_y = '0; alu_sub = 1'b1;
    mul_a = '0; mul_b = '0;
    store_neg = 1'b0;

    case (state_r)
      fadr_pkg::S_IDLE: begin
        if (in_tvalid) begin
          for (int i = 0; i < 4; i++) begin
            ops_nxt[i] = fld[i][W-1];
            opm_nxt[i] = fld[i][W-1] ? (W'(0) - fld[i]) : fld[i];
          end
          fixed_nxt = 1'b0;
          phase_nxt = fadr_pkg::PH_LEFT;
          state_nxt = fadr_pkg::S_LOAD;
        end
      end
      fadr_pkg::S_LOAD: begin
        if (phase_r == fadr_pkg::PH_LEFT) begin
          xn_nxt = DW'(opm_r[0]);
          xd_nxt = DW'(opm_r[1]);
          if (opm_r[1] == '0) begin
            ln_nxt = W'(1); ld_nxt = W'(1); lneg_nxt = 1'b0; fixed_nxt = 1'b1;
            phase_nxt = fadr_pkg::PH_RIGHT;
          end else begin
            state_nxt = fadr_pkg::S_GCD_INIT;
          end
        end else begin
          xn_nxt = DW'(opm_r[2]);
          xd_nxt = DW'(opm_r[3]);
          if (opm_r[3] == '0) begin
            rn_nxt = W'(1); rd_nxt = W'(1); rneg_nxt = 1'b0; fixed_nxt = 1'b1;
            cnt_nxt = '0;
            state_nxt = fadr_pkg::S_MUL;
          end else begin
            state_nxt = fadr_pkg::S_GCD_INIT;
          end
        end
      end
      fadr_pkg::S_GCD_INIT: begin
        a_nxt = xn_r; b_nxt = xd_r; k_nxt = '0;
        state_nxt = fadr_pkg::S_GCD;
      end
      fadr_pkg::S_GCD: begin
        alu_x = {1'b0, a_r};
        alu_y = {1'b0, b_r};
        if (a_r == '0 || b_r == '0) begin
          g_nxt = (a_r | b_r) << k_r[5:0];
          div_sel_nxt = 1'b0;
          state_nxt = fadr_pkg::S_DIV_INIT;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1; b_nxt = b_r >> 1; k_nxt = k_r + 7'd1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (borrow) begin
          a_nxt = b_r; b_nxt = a_r;
        end else begin
          a_nxt = alu_res[DW-1:0];
        end
      end
      fadr_pkg::S_DIV_INIT: begin
        rem_nxt = '0;
        q_nxt = div_sel_r ? xd_r : xn_r;
        cnt_nxt = '0;
        state_nxt = fadr_pkg::S_DIV;
      end
      fadr_pkg::S_DIV: begin
        alu_x = r2;
        alu_y = {1'b0, g_r};
        rem_nxt = borrow ? r2[DW-1:0] : alu_res[DW-1:0];
        q_nxt = {q_r[DW-2:0], ~borrow};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = fadr_pkg::S_STORE;
        end
      end
      fadr_pkg::S_STORE: begin
        if (!div_sel_r) begin
          xn_nxt = q_r;
          div_sel_nxt = 1'b1;
          state_nxt = fadr_pkg::S_DIV_INIT;
        end else begin
          xd_nxt = q_r;
          case (phase_r)
            fadr_pkg::PH_LEFT: begin
              store_neg = (xn_r != '0) && (ops_r[0] != ops_r[1]);
              ln_nxt = xn_r[W-1:0]; ld_nxt = store_mag_d; lneg_nxt = store_neg;
              phase_nxt = fadr_pkg::PH_RIGHT;
              state_nxt = fadr_pkg::S_LOAD;
            end
            fadr_pkg::PH_RIGHT: begin
              store_neg = (xn_r != '0) && (ops_r[2] != ops_r[3]);
              rn_nxt = xn_r[W-1:0]; rd_nxt = store_mag_n; rneg_nxt = store_neg;
              cnt_nxt = '0;
              state_nxt = fadr_pkg::S_MUL;
            end
            default: begin
              onum_nxt = (neg_r && xn_r != '0) ? (DW'(0) - xn_r) : xn_r;
              oden_nxt = q_r[DW-2:0];
              ofix_nxt = fixed_r;
              ovalid_nxt = 1'b1;
              state_nxt = fadr_pkg::S_OUT;
            end
          endcase
        end
      end
      fadr_pkg::S_MUL: begin
        cnt_nxt = cnt_r + 6'd1;
        case (cnt_r[1:0])
          2'd0: begin
            mul_a = ln_r; mul_b = rd_r; t1_nxt = mul_p;
          end
          2'd1: begin
            mul_a = rn_r; mul_b = ld_r; t2_nxt = mul_p;
          end
          default: begin
            mul_a = ld_r; mul_b = rd_r; den_nxt = mul_p;
            state_nxt = fadr_pkg::S_ADD;
          end
        endcase
      end
      fadr_pkg::S_ADD: begin
        alu_x = {1'b0, t1_r};
        alu_y = {1'b0, t2_r};
        alu_sub = (lneg_r != rneg_r);
        phase_nxt = fadr_pkg::PH_SUM;
        xd_nxt = den_r;
        xn_nxt = alu_res[DW-1:0];
        neg_nxt = lneg_r;
        if (alu_sub && borrow) begin
          state_nxt = fadr_pkg::S_ADD2;
        end else begin
          state_nxt = fadr_pkg::S_GCD_INIT;
        end
      end
      fadr_pkg::S_ADD2: begin
        alu_x = {1'b0, t2_r};
        alu_y = {1'b0, t1_r};
        xn_nxt = alu_res[DW-1:0];
        neg_nxt = rneg_r;
        state_nxt = fadr_pkg::S_GCD_INIT;
      end
      fadr_pkg::S_OUT: begin
        if (out_tready) begin
          ovalid_nxt = 1'b0;
          state_nxt = fadr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fadr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fadr_pkg::S_IDLE;
      ovalid_r <= 1'b0;
      phase_r  <= fadr_pkg::PH_LEFT;
      div_sel_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      phase_r  <= phase_nxt;
      div_sel_r <= div_sel_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt; a_r <= a_nxt; b_r <= b_nxt; xn_r <= xn_nxt; xd_r <= xd_nxt;
    g_r <= g_nxt; q_r <= q_nxt; rem_r <= rem_nxt;
    t1_r <= t1_nxt; t2_r <= t2_nxt; den_r <= den_nxt;
    neg_r <= neg_nxt; fixed_r <= fixed_nxt;
    ln_r <= ln_nxt; ld_r <= ld_nxt; rn_r <= rn_nxt; rd_r <= rd_nxt;
    lneg_r <= lneg_nxt; rneg_r <= rneg_nxt;
    onum_r <= onum_nxt; oden_r <= oden_nxt; ofix_r <= ofix_nxt;
    for (int i = 0; i < 4; i++) begin
      opm_r[i] <= opm_nxt[i];
      ops_r[i] <= ops_nxt[i];
    end
  end

  assign in_tready  = (state_r == fadr_pkg::S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, oden_r, onum_r};
  assign out_tuser  = ofix_r;

endmodule
